@@ design/nfam_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// nfam_pkg: shared types and constants of the NAND flash array model
// Array geometry, field widths, request codes and the controller/datapath
// command and status structs.
// ---------------------------------------------------------------------------
package nfam_pkg;

    // array geometry
    localparam int PAGE_BYTES     = 512;
    localparam int PAGES_IN_BLOCK = 32;
    localparam int PAGE_COUNT     = 256;
    localparam int BLOCK_COUNT    = PAGE_COUNT / PAGES_IN_BLOCK;
    localparam int BLOCK_BYTES    = PAGES_IN_BLOCK * PAGE_BYTES;
    localparam int ARRAY_BYTES    = PAGE_COUNT * PAGE_BYTES;
    localparam int ADDR_W         = $clog2(ARRAY_BYTES);

    // transaction field widths
    localparam int REQ_W      = 4;
    localparam int PAGE_W     = 8;
    localparam int OFF_W      = 9;
    localparam int DATA_W     = 8;
    localparam int BLK_W      = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 9;

    // byte constants
    localparam logic [DATA_W-1:0] BYTE_ERASED = 8'hFF;
    localparam logic [DATA_W-1:0] MASK_USED   = 8'hF0;
    localparam logic [DATA_W-1:0] MASK_BAD    = 8'h00;
    localparam logic [DATA_W-1:0] STATUS_OK   = 8'h40;

    // reset values of the mark offset registers
    localparam logic [OFF_W-1:0] BAD_OFF_RST  = 9'd0;
    localparam logic [OFF_W-1:0] USED_OFF_RST = 9'd1;

    typedef enum logic [REQ_W-1:0] {
        REQ_READ        = 4'd0,
        REQ_PROGRAM     = 4'd1,
        REQ_COPY        = 4'd2,
        REQ_ERASE_BLOCK = 4'd3,
        REQ_VALID_Q     = 4'd4,
        REQ_ERASED_Q    = 4'd5,
        REQ_MARK_BAD    = 4'd6,
        REQ_MARK_USED   = 4'd7,
        REQ_ERASE_ALL   = 4'd8
    } t_req_type;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BAD_OFF  = 1'b0,
        CFG_USED_OFF = 1'b1
    } t_cfg_idx;

    // which address the datapath drives to the array
    typedef enum logic [1:0] {
        ASEL_A     = 2'd0,
        ASEL_B     = 2'd1,
        ASEL_SWEEP = 2'd2
    } t_addr_sel;

    typedef struct packed {
        logic      load_req;
        logic      ram_re;
        logic      ram_we;
        t_addr_sel addr_sel;
        logic      cap_a;
        logic      cap_b;
        logic      cnt_clr;
        logic      cnt_inc;
        logic      load_rsp;
    } t_dp_cmd;

    typedef struct packed {
        t_req_type req;
        logic      oor;
        logic      both_ff;
        logic      cnt_last;
    } t_dp_status;

endpackage
`default_nettype wire

@@ design/nfam_req_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// nfam_req_if: request channel
// Valid/ready channel that carries one flash request per transaction.
// ---------------------------------------------------------------------------
interface nfam_req_if
    import nfam_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [REQ_W-1:0]    req_type;
    logic [PAGE_W-1:0]   page_index;
    logic [OFF_W-1:0]    byte_offset;
    logic [DATA_W-1:0]   write_data;
    logic [PAGE_W-1:0]   target_page;
    logic [BLK_W-1:0]    block_index;

    modport source (
        output valid, req_type, page_index, byte_offset, write_data,
               target_page, block_index,
        input  ready
    );

    modport sink (
        input  valid, req_type, page_index, byte_offset, write_data,
               target_page, block_index,
        output ready
    );
endinterface
`default_nettype wire

@@ design/nfam_rsp_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// nfam_rsp_if: response channel
// Valid/ready channel that carries one result per transaction.
// ---------------------------------------------------------------------------
interface nfam_rsp_if
    import nfam_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [DATA_W-1:0]   read_data;
    logic [DATA_W-1:0]   status_byte;
    logic                block_flag;
    logic                out_of_range;

    modport source (
        output valid, read_data, status_byte, block_flag, out_of_range,
        input  ready
    );

    modport sink (
        input  valid, read_data, status_byte, block_flag, out_of_range,
        output ready
    );
endinterface
`default_nettype wire

@@ design/nfam_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// nfam_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data is registered.
// ---------------------------------------------------------------------------
module nfam_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

@@ design/nfam_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// nfam_dp: datapath of the NAND flash array model
// Holds the request fields, mark offset registers, sweep counter, the byte
// array and the response payload; forms addresses and write data.
// ---------------------------------------------------------------------------
module nfam_dp
    import nfam_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_dp_cmd               i_cmd,
    output t_dp_status                 o_status,
    input  wire logic [REQ_W-1:0]      i_req_type,
    input  wire logic [PAGE_W-1:0]     i_page_index,
    input  wire logic [OFF_W-1:0]      i_byte_offset,
    input  wire logic [DATA_W-1:0]     i_write_data,
    input  wire logic [PAGE_W-1:0]     i_target_page,
    input  wire logic [BLK_W-1:0]      i_block_index,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic      [DATA_W-1:0]     o_read_data,
    output logic      [DATA_W-1:0]     o_status_byte,
    output logic                       o_block_flag,
    output logic                       o_out_of_range
);
    // latched request
    t_req_type          r_req;
    logic [PAGE_W-1:0]  r_page;
    logic [OFF_W-1:0]   r_off;
    logic [DATA_W-1:0]  r_data;
    logic [PAGE_W-1:0]  r_target;
    logic [BLK_W-1:0]   r_blk;

    // mark offset registers
    logic [OFF_W-1:0]   r_bad_off;
    logic [OFF_W-1:0]   r_used_off;

    // sweep / copy byte counter
    logic [ADDR_W-1:0]  r_cnt;
    logic [ADDR_W-1:0]  n_cnt;

    // captured array bytes
    logic [DATA_W-1:0]  r_da;
    logic [DATA_W-1:0]  r_db;
    logic               r_both;

    // response payload
    logic [DATA_W-1:0]  r_rd;
    logic               r_flag;
    logic               r_oor;

    logic [DATA_W-1:0]  ram_rdata;
    logic [ADDR_W-1:0]  ram_addr;
    logic [DATA_W-1:0]  ram_wdata;

    logic [OFF_W-1:0]   mark_off;
    logic [DATA_W-1:0]  mark_mask;
    logic [ADDR_W-1:0]  blk_base;
    logic [ADDR_W-1:0]  addr_a;
    logic [ADDR_W-1:0]  addr_b;
    logic [ADDR_W-1:0]  sweep_base;
    logic               page_ok;
    logic               off_ok;
    logic               target_ok;
    logic               block_ok;
    logic               bad_ok;
    logic               used_ok;
    logic               oor;
    logic               is_query;
    logic               cnt_last;

    // request capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_req    <= t_req_type'(i_req_type);
            r_page   <= i_page_index;
            r_off    <= i_byte_offset;
            r_data   <= i_write_data;
            r_target <= i_target_page;
            r_blk    <= i_block_index;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bad_off  <= BAD_OFF_RST;
            r_used_off <= USED_OFF_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_BAD_OFF:  r_bad_off  <= i_cfg_data;
                CFG_USED_OFF: r_used_off <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // range checks
    always_comb begin
        page_ok   = 32'(r_page) < 32'(PAGE_COUNT);
        off_ok    = 32'(r_off) < 32'(PAGE_BYTES);
        target_ok = 32'(r_target) < 32'(PAGE_COUNT);
        block_ok  = 32'(r_blk) < 32'(BLOCK_COUNT);
        bad_ok    = block_ok && (32'(r_bad_off) < 32'(PAGE_BYTES));
        used_ok   = block_ok && (32'(r_used_off) < 32'(PAGE_BYTES));
        case (r_req)
            REQ_READ, REQ_PROGRAM:                          oor = !(page_ok && off_ok);
            REQ_COPY:                                       oor = !(page_ok && target_ok);
            REQ_ERASE_BLOCK, REQ_VALID_Q, REQ_MARK_BAD:     oor = !bad_ok;
            REQ_ERASED_Q, REQ_MARK_USED:                    oor = !used_ok;
            default:                                        oor = 1'b0;
        endcase
        is_query = (r_req == REQ_VALID_Q) || (r_req == REQ_ERASED_Q);
    end

    // mark offset and mask by request
    always_comb begin
        if ((r_req == REQ_ERASED_Q) || (r_req == REQ_MARK_USED)) begin
            mark_off  = r_used_off;
            mark_mask = MASK_USED;
        end else begin
            mark_off  = r_bad_off;
            mark_mask = MASK_BAD;
        end
    end

    // address generation
    always_comb begin
        blk_base = ADDR_W'(r_blk) * ADDR_W'(BLOCK_BYTES);
        case (r_req)
            REQ_READ, REQ_PROGRAM: begin
                addr_a = ADDR_W'(r_page) * ADDR_W'(PAGE_BYTES) + ADDR_W'(r_off);
                addr_b = addr_a;
            end
            REQ_COPY: begin
                addr_a = ADDR_W'(r_page) * ADDR_W'(PAGE_BYTES) + r_cnt;
                addr_b = ADDR_W'(r_target) * ADDR_W'(PAGE_BYTES) + r_cnt;
            end
            default: begin
                addr_a = blk_base + ADDR_W'(mark_off);
                addr_b = blk_base + ADDR_W'(PAGE_BYTES) + ADDR_W'(mark_off);
            end
        endcase
        sweep_base = (r_req == REQ_ERASE_ALL) ? '0 : blk_base;
        case (i_cmd.addr_sel)
            ASEL_A:     ram_addr = addr_a;
            ASEL_B:     ram_addr = addr_b;
            ASEL_SWEEP: ram_addr = sweep_base + r_cnt;
            default:    ram_addr = addr_a;
        endcase
    end

    // write data: program and marks clear bits, copy ANDs source into target
    always_comb begin
        case (i_cmd.addr_sel)
            ASEL_A:     ram_wdata = (r_req == REQ_PROGRAM) ? (r_da & r_data)
                                                           : (r_da & mark_mask);
            ASEL_B:     ram_wdata = (r_req == REQ_COPY) ? (r_db & r_da)
                                                        : (r_db & mark_mask);
            ASEL_SWEEP: ram_wdata = BYTE_ERASED;
            default:    ram_wdata = BYTE_ERASED;
        endcase
    end

    // byte counter and its terminal value per request
    always_comb begin
        case (r_req)
            REQ_COPY:        cnt_last = (r_cnt == ADDR_W'(PAGE_BYTES - 1));
            REQ_ERASE_BLOCK: cnt_last = (r_cnt == ADDR_W'(BLOCK_BYTES - 1));
            default:         cnt_last = (r_cnt == ADDR_W'(ARRAY_BYTES - 1));
        endcase
        if (i_cmd.cnt_clr) begin
            n_cnt = '0;
        end else if (i_cmd.cnt_inc) begin
            n_cnt = cnt_last ? '0 : r_cnt + 1'b1;
        end else begin
            n_cnt = r_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    // capture of the two bytes read
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_a) begin
            r_da <= ram_rdata;
        end
        if (i_cmd.cap_b) begin
            r_db   <= ram_rdata;
            r_both <= (r_da == BYTE_ERASED) && (ram_rdata == BYTE_ERASED);
        end
    end

    // response payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_rsp) begin
            r_rd   <= ((r_req == REQ_READ) && !oor) ? r_da : '0;
            r_flag <= is_query && !oor && r_both;
            r_oor  <= oor;
        end
    end

    nfam_ram #(
        .WIDTH (DATA_W),
        .DEPTH (ARRAY_BYTES)
    ) u_array (
        .i_clk   (i_clk),
        .i_we    (i_cmd.ram_we),
        .i_waddr (ram_addr),
        .i_wdata (ram_wdata),
        .i_re    (i_cmd.ram_re),
        .i_raddr (ram_addr),
        .o_rdata (ram_rdata)
    );

    assign o_status.req      = r_req;
    assign o_status.oor      = oor;
    assign o_status.both_ff  = (r_da == BYTE_ERASED) && (ram_rdata == BYTE_ERASED);
    assign o_status.cnt_last = cnt_last;

    assign o_read_data    = r_rd;
    assign o_status_byte  = STATUS_OK;
    assign o_block_flag   = r_flag;
    assign o_out_of_range = r_oor;
endmodule
`default_nettype wire

@@ design/nfam_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// nfam_ctrl: sequencer of the NAND flash array model
// One-hot state machine that steps each request through reads, writes and
// sweeps of the array, and owns the handshake valid/ready flags.
// ---------------------------------------------------------------------------
module nfam_ctrl
    import nfam_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_req_valid,
    output logic             o_req_ready,
    output logic             o_rsp_valid,
    input  wire logic        i_rsp_ready,
    output t_dp_cmd          o_cmd,
    input  wire t_dp_status  i_status
);
    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_DECODE = 9'b000000010,
        S_RDA    = 9'b000000100,
        S_RDB    = 9'b000001000,
        S_EVAL   = 9'b000010000,
        S_WRA    = 9'b000100000,
        S_WRB    = 9'b001000000,
        S_SWEEP  = 9'b010000000,
        S_DONE   = 9'b100000000
    } t_state;

    t_state  r_state;
    t_state  n_state;
    logic    r_rsp_valid;
    logic    n_rsp_valid;
    t_dp_cmd cmd;

    // next state and datapath commands
    always_comb begin
        n_state      = r_state;
        cmd          = '0;
        cmd.addr_sel = ASEL_A;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    cmd.load_req = 1'b1;
                    n_state      = S_DECODE;
                end
            end
            S_DECODE: begin
                cmd.cnt_clr = 1'b1;
                case (i_status.req)
                    REQ_READ, REQ_PROGRAM, REQ_COPY, REQ_ERASE_BLOCK, REQ_VALID_Q,
                    REQ_ERASED_Q, REQ_MARK_BAD, REQ_MARK_USED: begin
                        n_state = i_status.oor ? S_DONE : S_RDA;
                    end
                    REQ_ERASE_ALL: n_state = S_SWEEP;
                    default:       n_state = S_DONE;
                endcase
            end
            S_RDA: begin
                cmd.ram_re = 1'b1;
                n_state    = S_RDB;
            end
            S_RDB: begin
                cmd.ram_re   = 1'b1;
                cmd.addr_sel = ASEL_B;
                cmd.cap_a    = 1'b1;
                n_state      = S_EVAL;
            end
            S_EVAL: begin
                cmd.cap_b = 1'b1;
                case (i_status.req)
                    REQ_PROGRAM, REQ_MARK_BAD, REQ_MARK_USED: n_state = S_WRA;
                    REQ_COPY:        n_state = S_WRB;
                    REQ_ERASE_BLOCK: n_state = i_status.both_ff ? S_SWEEP : S_DONE;
                    default:         n_state = S_DONE;
                endcase
            end
            S_WRA: begin
                cmd.ram_we = 1'b1;
                if ((i_status.req == REQ_MARK_BAD) || (i_status.req == REQ_MARK_USED)) begin
                    n_state = S_WRB;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_WRB: begin
                cmd.ram_we   = 1'b1;
                cmd.addr_sel = ASEL_B;
                if (i_status.req == REQ_COPY) begin
                    cmd.cnt_inc = 1'b1;
                    n_state     = i_status.cnt_last ? S_DONE : S_RDA;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SWEEP: begin
                cmd.ram_we   = 1'b1;
                cmd.addr_sel = ASEL_SWEEP;
                cmd.cnt_inc  = 1'b1;
                if (i_status.cnt_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_rsp_valid || i_rsp_ready) begin
                    cmd.load_rsp = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // output register valid flag
    always_comb begin
        if (cmd.load_rsp) begin
            n_rsp_valid = 1'b1;
        end else if (i_rsp_ready) begin
            n_rsp_valid = 1'b0;
        end else begin
            n_rsp_valid = r_rsp_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    assign o_cmd       = cmd;
    assign o_req_ready = (r_state == S_IDLE);
    assign o_rsp_valid = r_rsp_valid;
endmodule
`default_nettype wire

@@ design/nand_flash_array_model.sv @@
// Requests are decoded; out-of-range or unknown ones go straight to the result,
// erase all sweeps the array, one byte written per cycle. The rest read two
// bytes; program then writes one, marks two, copy the target byte over a page
// on one array port; erase block sweeps a block whose bad marks read 0xFF.
// One request in flight, next taken in the cycle after its result loads, even
// while it waits. Sync reset clears control, byte counter, mark offsets only.
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// nand_flash_array_model: NAND flash array emulation
// Byte array with program-clears-bits, block erase, page copy and
// bad-block/used marks, driven by a valid/ready request channel.
// ---------------------------------------------------------------------------
module nand_flash_array_model
    import nfam_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    nfam_req_if.sink                   i_req,
    nfam_rsp_if.source                 o_rsp,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);
    t_dp_cmd    cmd;
    t_dp_status status;

    // sequencer
    nfam_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .o_rsp_valid (o_rsp.valid),
        .i_rsp_ready (o_rsp.ready),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    // array and payload datapath
    nfam_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_req_type     (i_req.req_type),
        .i_page_index   (i_req.page_index),
        .i_byte_offset  (i_req.byte_offset),
        .i_write_data   (i_req.write_data),
        .i_target_page  (i_req.target_page),
        .i_block_index  (i_req.block_index),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .o_read_data    (o_rsp.read_data),
        .o_status_byte  (o_rsp.status_byte),
        .o_block_flag   (o_rsp.block_flag),
        .o_out_of_range (o_rsp.out_of_range)
    );
endmodule
`default_nettype wire

@@ test/nand_flash_array_model_test.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// nand_flash_array_model_test: self-checking bench for the NAND array model
// Wipes the array first and walks a short list of hand-picked requests. It
// then runs random request mixes under four mark offset settings. A local
// copy of the array and of the mark offsets predicts every response, and
// each one is checked field by field.
// ---------------------------------------------------------------------------
module nand_flash_array_model_test;
    import nfam_pkg::*;

    localparam int HALF_PERIOD_NS   = 2;
    localparam int RESET_CYCLES     = 9;
    localparam int PHASES           = 4;
    localparam int RANDOM_PER_PHASE = 200;
    localparam int DRAIN_CYCLES     = 16;
    localparam int PRINT_LIMIT      = 200;
    // slowest request is a full array wipe, one byte per cycle
    localparam int WATCHDOG_CYCLES  = 4 * ARRAY_BYTES;

    // request codes with no meaning to the block
    localparam logic [REQ_W-1:0] REQ_FIRST_UNUSED = 4'd9;
    localparam logic [REQ_W-1:0] REQ_LAST_UNUSED  = 4'd15;

    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [PAGE_W-1:0] page;
        logic [OFF_W-1:0]  off;
        logic [DATA_W-1:0] wdata;
        logic [PAGE_W-1:0] target;
        logic [BLK_W-1:0]  block;
    } flash_req_t;

    typedef struct packed {
        logic [DATA_W-1:0] rdata;
        logic [DATA_W-1:0] status;
        logic              flag;
        logic              oor;
    } flash_rsp_t;

    // response override for hand-checked requests
    typedef struct packed {
        logic       typed;
        flash_rsp_t want;
    } result_tag_t;

    typedef struct packed {
        flash_req_t  req;
        result_tag_t tag;
    } directed_entry_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    nfam_req_if req_ch ();
    nfam_rsp_if rsp_ch ();

    nand_flash_array_model DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_ch),
        .o_rsp      (rsp_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #HALF_PERIOD_NS i_clk = ~i_clk;

    // shadow of the array and of the mark offset registers
    logic [DATA_W-1:0] flash_image [ARRAY_BYTES];
    logic [OFF_W-1:0]  bad_mark_off  = BAD_OFF_RST;
    logic [OFF_W-1:0]  used_mark_off = USED_OFF_RST;

    flash_rsp_t      expected_q [$];
    result_tag_t     tag_q [$];
    directed_entry_t directed_list [$];

    int  fail_count      = 0;
    int  results_checked = 0;
    int  idle_cycles     = 0;
    bit  steady_run      = 1'b0;

    // ------------------------------------------------------------------
    // array predictor
    // ------------------------------------------------------------------
    function automatic int unsigned byte_addr(int unsigned page, int unsigned off);
        return page * PAGE_BYTES + off;
    endfunction

    // both first pages of the block hold 0xFF at the offset
    function automatic bit marks_all_ones(int unsigned block, int unsigned off);
        int unsigned first;
        first = block * PAGES_IN_BLOCK;
        return flash_image[byte_addr(first, off)] == BYTE_ERASED &&
               flash_image[byte_addr(first + 1, off)] == BYTE_ERASED;
    endfunction

    function automatic void clear_marks(int unsigned block, int unsigned off,
                                        logic [DATA_W-1:0] mask);
        int unsigned first;
        first = block * PAGES_IN_BLOCK;
        flash_image[byte_addr(first, off)]     &= mask;
        flash_image[byte_addr(first + 1, off)] &= mask;
    endfunction

    function automatic flash_rsp_t apply_request(flash_req_t r);
        flash_rsp_t  res;
        bit          blk_ok, bad_ok, used_ok, page_ok;
        int unsigned base;
        res.rdata  = '0;
        res.status = STATUS_OK;
        res.flag   = 1'b0;
        res.oor    = 1'b0;
        blk_ok  = r.block < BLOCK_COUNT;
        bad_ok  = blk_ok && bad_mark_off < PAGE_BYTES;
        used_ok = blk_ok && used_mark_off < PAGE_BYTES;
        page_ok = r.page < PAGE_COUNT && r.off < PAGE_BYTES;
        case (r.req_type)
            REQ_READ: begin
                if (page_ok) res.rdata = flash_image[byte_addr(r.page, r.off)];
                else res.oor = 1'b1;
            end
            REQ_PROGRAM: begin
                if (page_ok) flash_image[byte_addr(r.page, r.off)] &= r.wdata;
                else res.oor = 1'b1;
            end
            REQ_COPY: begin
                if (r.page < PAGE_COUNT && r.target < PAGE_COUNT) begin
                    for (int i = 0; i < PAGE_BYTES; i++)
                        flash_image[byte_addr(r.target, i)] &=
                            flash_image[byte_addr(r.page, i)];
                end else begin
                    res.oor = 1'b1;
                end
            end
            REQ_ERASE_BLOCK: begin
                if (!bad_ok) begin
                    res.oor = 1'b1;
                end else if (marks_all_ones(r.block, bad_mark_off)) begin
                    base = byte_addr(r.block * PAGES_IN_BLOCK, 0);
                    for (int i = 0; i < BLOCK_BYTES; i++)
                        flash_image[base + i] = BYTE_ERASED;
                end
            end
            REQ_VALID_Q: begin
                if (bad_ok) res.flag = marks_all_ones(r.block, bad_mark_off);
                else res.oor = 1'b1;
            end
            REQ_ERASED_Q: begin
                if (used_ok) res.flag = marks_all_ones(r.block, used_mark_off);
                else res.oor = 1'b1;
            end
            REQ_MARK_BAD: begin
                if (bad_ok) clear_marks(r.block, bad_mark_off, MASK_BAD);
                else res.oor = 1'b1;
            end
            REQ_MARK_USED: begin
                if (used_ok) clear_marks(r.block, used_mark_off, MASK_USED);
                else res.oor = 1'b1;
            end
            REQ_ERASE_ALL: begin
                for (int i = 0; i < ARRAY_BYTES; i++)
                    flash_image[i] = BYTE_ERASED;
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic directed_entry_t directed_entry(
            logic [REQ_W-1:0] req, logic [PAGE_W-1:0] page, logic [OFF_W-1:0] off,
            logic [DATA_W-1:0] wdata, logic [PAGE_W-1:0] target,
            logic [BLK_W-1:0] block, logic typed, logic [DATA_W-1:0] rdata,
            logic flag);
        directed_entry_t e;
        e.req.req_type    = req;
        e.req.page        = page;
        e.req.off         = off;
        e.req.wdata       = wdata;
        e.req.target      = target;
        e.req.block       = block;
        e.tag.typed       = typed;
        e.tag.want.rdata  = rdata;
        e.tag.want.status = STATUS_OK;
        e.tag.want.flag   = flag;
        e.tag.want.oor    = 1'b0;
        return e;
    endfunction

    // random request, weighted toward the mark bytes of the first two pages
    function automatic flash_req_t pick_request();
        flash_req_t  r;
        int unsigned roll;
        int unsigned blk;
        r.page   = $urandom_range(PAGE_COUNT - 1);
        r.off    = $urandom_range(PAGE_BYTES - 1);
        r.wdata  = $urandom_range(255);
        r.target = $urandom_range(PAGE_COUNT - 1);
        r.block  = $urandom_range(7);
        roll = $urandom_range(999);
        if (roll < 430)      r.req_type = REQ_READ;
        else if (roll < 650) r.req_type = REQ_PROGRAM;
        else if (roll < 690) r.req_type = REQ_COPY;
        else if (roll < 705) r.req_type = REQ_ERASE_BLOCK;
        else if (roll < 805) r.req_type = REQ_VALID_Q;
        else if (roll < 905) r.req_type = REQ_ERASED_Q;
        else if (roll < 925) r.req_type = REQ_MARK_BAD;
        else if (roll < 980) r.req_type = REQ_MARK_USED;
        else r.req_type = $urandom_range(REQ_LAST_UNUSED, REQ_FIRST_UNUSED);
        blk = $urandom_range(BLOCK_COUNT - 1);
        if ($urandom_range(1) == 1)
            r.page = blk * PAGES_IN_BLOCK + $urandom_range(1);
        if ($urandom_range(1) == 1)
            r.off = ($urandom_range(1) == 1) ? bad_mark_off : used_mark_off;
        roll = $urandom_range(9);
        if (roll < 3)      r.wdata = BYTE_ERASED;
        else if (roll < 5) r.wdata = ~(8'h01 << $urandom_range(7));
        roll = $urandom_range(9);
        if (roll == 0)
            r.target = r.page;
        else if (roll < 4)
            r.target = $urandom_range(BLOCK_COUNT - 1) * PAGES_IN_BLOCK
                       + $urandom_range(1);
        return r;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 55) return 0;
        if (roll < 92) return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    task automatic send_request(input flash_req_t r, input result_tag_t tag);
        int gap;
        gap = steady_run ? 0 : pick_gap();
        if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        tag_q.push_back(tag);
        req_ch.valid       <= 1'b1;
        req_ch.req_type    <= r.req_type;
        req_ch.page_index  <= r.page;
        req_ch.byte_offset <= r.off;
        req_ch.write_data  <= r.wdata;
        req_ch.target_page <= r.target;
        req_ch.block_index <= r.block;
        do @(posedge i_clk); while (!req_ch.ready);
    endtask

    // both registers are written back to back while the block is idle
    task automatic write_mark_offsets(input logic [OFF_W-1:0] bad_off,
                                      input logic [OFF_W-1:0] used_off);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_BAD_OFF;
        i_cfg_data <= bad_off;
        @(posedge i_clk);
        bad_mark_off = bad_off;
        i_cfg_idx  <= CFG_USED_OFF;
        i_cfg_data <= used_off;
        @(posedge i_clk);
        used_mark_off = used_off;
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_until_drained();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic report_failure(input string msg);
        if (fail_count < PRINT_LIMIT)
            $display("ERROR: response %0d: %s", results_checked, msg);
        fail_count++;
    endtask

    task automatic check_field(input string name, input logic [DATA_W-1:0] got,
                               input logic [DATA_W-1:0] want);
        if (got !== want)
            report_failure($sformatf("%s got %h expected %h", name, got, want));
    endtask

    // ------------------------------------------------------------------
    // response side backpressure
    // ------------------------------------------------------------------
    initial begin : response_stall
        int stall_left;
        stall_left = 0;
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_left != 0) begin
                rsp_ch.ready <= 1'b0;
                stall_left--;
            end else if (!steady_run && $urandom_range(99) < 25) begin
                rsp_ch.ready <= 1'b0;
                stall_left = ($urandom_range(9) == 0) ? $urandom_range(60, 10)
                                                      : $urandom_range(2);
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // transaction monitor: predict on request, check on response
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        flash_req_t  seen;
        flash_rsp_t  pred;
        flash_rsp_t  want;
        result_tag_t tag;
        bit          moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (req_ch.valid && req_ch.ready) begin
                seen.req_type = req_ch.req_type;
                seen.page     = req_ch.page_index;
                seen.off      = req_ch.byte_offset;
                seen.wdata    = req_ch.write_data;
                seen.target   = req_ch.target_page;
                seen.block    = req_ch.block_index;
                pred = apply_request(seen);
                if (tag_q.size() != 0) begin
                    tag = tag_q.pop_front();
                    if (tag.typed) pred = tag.want;
                end
                expected_q.push_back(pred);
                moved = 1'b1;
            end
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (expected_q.size() == 0) begin
                    report_failure("response with no request outstanding");
                end else begin
                    want = expected_q.pop_front();
                    check_field("read_data", rsp_ch.read_data, want.rdata);
                    check_field("status_byte", rsp_ch.status_byte, want.status);
                    check_field("block_flag", rsp_ch.block_flag, want.flag);
                    check_field("out_of_range", rsp_ch.out_of_range, want.oor);
                end
                results_checked++;
                moved = 1'b1;
            end
            // watchdog on cycles with no transaction on either channel
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_CYCLES) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        logic [OFF_W-1:0] phase_bad  [PHASES];
        logic [OFF_W-1:0] phase_used [PHASES];
        flash_req_t       wipe;
        result_tag_t      no_tag;

        i_rst_n            <= 1'b0;
        i_cfg_we           <= 1'b0;
        i_cfg_idx          <= CFG_BAD_OFF;
        i_cfg_data         <= '0;
        req_ch.valid       <= 1'b0;
        req_ch.req_type    <= REQ_READ;
        req_ch.page_index  <= '0;
        req_ch.byte_offset <= '0;
        req_ch.write_data  <= '0;
        req_ch.target_page <= '0;
        req_ch.block_index <= '0;

        no_tag = '0;
        wipe   = '0;
        wipe.req_type = REQ_ERASE_ALL;

        // mark offsets per phase: reset values, extremes, shared byte, random
        phase_bad[0]  = BAD_OFF_RST;
        phase_used[0] = USED_OFF_RST;
        phase_bad[1]  = 9'd511;
        phase_used[1] = 9'd0;
        phase_bad[2]  = 9'd300;
        phase_used[2] = 9'd300;
        phase_bad[3]  = $urandom_range(PAGE_BYTES - 1);
        phase_used[3] = $urandom_range(PAGE_BYTES - 1);

        // hand-picked requests, mark offsets at reset values; the wipe comes
        // first so that no byte is touched before it is defined
        directed_list.push_back(directed_entry(REQ_ERASE_ALL, 0, 0, 0, 0, 0, 1, 8'h00, 0));
        directed_list.push_back(directed_entry(REQ_READ, 0, 0, 0, 0, 0, 1, 8'hFF, 0));
        directed_list.push_back(directed_entry(REQ_READ, 255, 511, 0, 0, 0, 1, 8'hFF, 0));
        directed_list.push_back(directed_entry(REQ_VALID_Q, 0, 0, 0, 0, 0, 1, 8'h00, 1));
        directed_list.push_back(directed_entry(REQ_ERASED_Q, 0, 0, 0, 0, 7, 1, 8'h00, 1));
        directed_list.push_back(directed_entry(REQ_PROGRAM, 255, 511, 8'h00, 0, 0,
                                               1, 8'h00, 0));
        directed_list.push_back(directed_entry(REQ_READ, 255, 511, 0, 0, 0, 1, 8'h00, 0));
        // program only clears bits, then copy ANDs a page into another
        directed_list.push_back(directed_entry(REQ_PROGRAM, 3, 5, 8'hA5, 0, 0, 0, 0, 0));
        directed_list.push_back(directed_entry(REQ_PROGRAM, 3, 5, 8'h0F, 0, 0, 0, 0, 0));
        directed_list.push_back(directed_entry(REQ_READ, 3, 5, 0, 0, 0, 0, 0, 0));
        directed_list.push_back(directed_entry(REQ_COPY, 3, 0, 0, 40, 0, 0, 0, 0));
        directed_list.push_back(directed_entry(REQ_READ, 40, 5, 0, 0, 0, 0, 0, 0));
        directed_list.push_back(directed_entry(REQ_PROGRAM, 40, 6, 8'h3C, 0, 0, 0, 0, 0));
        // copy of a page onto itself
        directed_list.push_back(directed_entry(REQ_COPY, 40, 0, 0, 40, 0, 0, 0, 0));
        directed_list.push_back(directed_entry(REQ_READ, 40, 6, 0, 0, 0, 0, 0, 0));
        // used mark, then erase of a valid block
        directed_list.push_back(directed_entry(REQ_MARK_USED, 0, 0, 0, 0, 1, 0, 0, 0));
        directed_list.push_back(directed_entry(REQ_ERASED_Q, 0, 0, 0, 0, 1, 0, 0, 0));
        directed_list.push_back(directed_entry(REQ_ERASE_BLOCK, 0, 0, 0, 0, 1, 0, 0, 0));
        directed_list.push_back(directed_entry(REQ_ERASED_Q, 0, 0, 0, 0, 1, 0, 0, 0));
        // bad mark, then erase of an invalid block leaves it alone
        directed_list.push_back(directed_entry(REQ_MARK_BAD, 0, 0, 0, 0, 7, 0, 0, 0));
        directed_list.push_back(directed_entry(REQ_VALID_Q, 0, 0, 0, 0, 7, 0, 0, 0));
        directed_list.push_back(directed_entry(REQ_ERASE_BLOCK, 0, 0, 0, 0, 7, 0, 0, 0));
        directed_list.push_back(directed_entry(REQ_READ, 224, 0, 0, 0, 0, 0, 0, 0));
        // unknown request codes answer with status only
        directed_list.push_back(directed_entry(REQ_FIRST_UNUSED, 0, 0, 0, 0, 0,
                                               1, 8'h00, 0));
        directed_list.push_back(directed_entry(REQ_LAST_UNUSED, 255, 511, 8'hFF, 255, 7,
                                               1, 8'h00, 0));

        // reset
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int phase = 0; phase < PHASES; phase++) begin
            write_mark_offsets(phase_bad[phase], phase_used[phase]);
            if (phase == 0) begin
                foreach (directed_list[k])
                    send_request(directed_list[k].req, directed_list[k].tag);
            end
            // fresh array halfway through, since marks pile up
            if (phase == 2)
                send_request(wipe, no_tag);
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                if ($urandom_range(49) == 0)
                    steady_run = ~steady_run;
                send_request(pick_request(), no_tag);
            end
            steady_run = 1'b0;
            wait_until_drained();
        end

        // verdict
        if (fail_count == 0 && expected_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
